>>> src/qeo_pkg.sv
package qeo_pkg;

    typedef enum logic [2:0] {
        OP_INIT        = 3'd0,
        OP_SAMPLE      = 3'd1,
        OP_READ_SPEED  = 3'd2,
        OP_ODOM_UPDATE = 3'd3,
        OP_ODOM_RESET  = 3'd4,
        OP_ODOM_READ   = 3'd5
    } op_t;

    // control that the top level hands to each wheel when a beat is processed
    typedef struct packed {
        logic fire;
        op_t  op;
    } step_ctl_t;

    localparam int CountWidth = 32;
    localparam int DeltaWidth = 16;

    // x4 decode, indexed by {previous phase, current phase}
    localparam logic signed [1:0] X4_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    function automatic logic signed [1:0] x4_step(input logic [3:0] transition);
        return X4_TABLE[transition];
    endfunction

endpackage

>>> src/qeo_wheel.sv
module qeo_wheel (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  qeo_pkg::step_ctl_t                    ctl,
    input  logic [1:0]                            phase,
    input  logic signed [qeo_pkg::DeltaWidth-1:0] delta,
    output logic signed [qeo_pkg::CountWidth-1:0] speed,
    output logic signed [qeo_pkg::CountWidth-1:0] signed_total,
    output logic        [qeo_pkg::CountWidth-1:0] travel_total
);
    import qeo_pkg::*;

    logic [1:0]                   prev_reg, prev_next;
    logic [CountWidth-1:0]        window_reg, window_next;
    logic [CountWidth-1:0]        signed_reg, signed_next;
    logic [CountWidth-1:0]        travel_reg, travel_next;
    logic signed [1:0]            step;
    logic [CountWidth-1:0]        window_step;
    logic signed [DeltaWidth:0]   delta_wide;
    logic [DeltaWidth:0]          delta_mag;

    assign step        = x4_step({prev_reg, phase});
    assign window_step = window_reg + CountWidth'(step);
    assign delta_wide  = (DeltaWidth+1)'(delta);
    // most negative delta gives a magnitude one past the signed range, hence the extra bit
    assign delta_mag   = delta_wide[DeltaWidth] ? (DeltaWidth+1)'(-delta_wide)
                                                : (DeltaWidth+1)'(delta_wide);

    always_comb
    begin
        prev_next   = prev_reg;
        window_next = window_reg;
        signed_next = signed_reg;
        travel_next = travel_reg;
        unique case (ctl.op)
            OP_INIT:
            begin
                prev_next = phase;
            end
            OP_SAMPLE:
            begin
                prev_next   = phase;
                window_next = window_step;
            end
            OP_READ_SPEED:
            begin
                window_next = '0;
            end
            OP_ODOM_UPDATE:
            begin
                signed_next = signed_reg + CountWidth'(delta);
                travel_next = travel_reg + CountWidth'(delta_mag);
            end
            OP_ODOM_RESET:
            begin
                signed_next = '0;
                travel_next = '0;
            end
            default:
            begin
                prev_next = prev_reg;
            end
        endcase
    end

    // read_speed reports the count before the clear
    assign speed        = (ctl.op == OP_SAMPLE) ? signed'(window_step) : signed'(window_reg);
    assign signed_total = signed'(signed_next);
    assign travel_total = travel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            window_reg <= '0;
            signed_reg <= '0;
            travel_reg <= '0;
        end
        else if (ctl.fire)
        begin
            prev_reg   <= prev_next;
            window_reg <= window_next;
            signed_reg <= signed_next;
            travel_reg <= travel_next;
        end
    end

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && ctl.op == OP_READ_SPEED |=> window_reg == '0)
        else $error("window count not cleared after read_speed");

    a_sample_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && ctl.op == OP_SAMPLE |=> prev_reg == $past(phase))
        else $error("previous phase not updated on sample");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.fire |=> $stable(window_reg) && $stable(signed_reg) && $stable(travel_reg))
        else $error("wheel state changed without a beat");

    a_reset_totals: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && ctl.op == OP_ODOM_RESET |=> signed_reg == '0 && travel_reg == '0)
        else $error("odometry totals not cleared");

endmodule

>>> src/quadrature_encoder_odometry.sv
// Two-wheel x4 quadrature decoder with odometry totals. Every input beat carries an
// operation (init, sample, read_speed, odometry_update, odometry_reset, odometry_read)
// and returns exactly one result beat with both window counts and all four totals.
// A beat is registered on entry, then decoded and applied to the wheel state once the
// result register can take it (it waits while the result side stalls), and lands in the
// result register; one beat per cycle sustained, limited only by the result side stalling.
module quadrature_encoder_odometry (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic [2:0]                            operation,
    input  logic                                  phase_a_left,
    input  logic                                  phase_b_left,
    input  logic                                  phase_a_right,
    input  logic                                  phase_b_right,
    input  logic signed [qeo_pkg::DeltaWidth-1:0] delta_left,
    input  logic signed [qeo_pkg::DeltaWidth-1:0] delta_right,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [qeo_pkg::CountWidth-1:0] speed_left,
    output logic signed [qeo_pkg::CountWidth-1:0] speed_right,
    output logic signed [qeo_pkg::CountWidth-1:0] signed_total_left,
    output logic signed [qeo_pkg::CountWidth-1:0] signed_total_right,
    output logic        [qeo_pkg::CountWidth-1:0] travel_total_left,
    output logic        [qeo_pkg::CountWidth-1:0] travel_total_right
);
    import qeo_pkg::*;

    logic                          item_valid_reg;
    logic [2:0]                    op_reg;
    logic [1:0]                    phase_left_reg, phase_right_reg;
    logic signed [DeltaWidth-1:0]  delta_left_reg, delta_right_reg;
    logic                          result_valid_reg;
    logic signed [CountWidth-1:0]  speed_left_reg, speed_right_reg;
    logic signed [CountWidth-1:0]  signed_left_reg, signed_right_reg;
    logic [CountWidth-1:0]         travel_left_reg, travel_right_reg;

    logic                          accept;
    logic                          advance;
    step_ctl_t                     ctl;
    logic signed [CountWidth-1:0]  speed_left_c, speed_right_c;
    logic signed [CountWidth-1:0]  signed_left_c, signed_right_c;
    logic [CountWidth-1:0]         travel_left_c, travel_right_c;

    // the held beat moves on when the result register is empty or being drained
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign ctl.fire = advance;
    assign ctl.op   = op_t'(op_reg);

    qeo_wheel u_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .phase        (phase_left_reg),
        .delta        (delta_left_reg),
        .speed        (speed_left_c),
        .signed_total (signed_left_c),
        .travel_total (travel_left_c)
    );

    qeo_wheel u_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .phase        (phase_right_reg),
        .delta        (delta_right_reg),
        .speed        (speed_right_c),
        .signed_total (signed_right_c),
        .travel_total (travel_right_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= operation;
            phase_left_reg  <= {phase_a_left, phase_b_left};
            phase_right_reg <= {phase_a_right, phase_b_right};
            delta_left_reg  <= delta_left;
            delta_right_reg <= delta_right;
        end
        if (advance)
        begin
            speed_left_reg   <= speed_left_c;
            speed_right_reg  <= speed_right_c;
            signed_left_reg  <= signed_left_c;
            signed_right_reg <= signed_right_c;
            travel_left_reg  <= travel_left_c;
            travel_right_reg <= travel_right_c;
        end
    end

    assign result_valid       = result_valid_reg;
    assign speed_left         = speed_left_reg;
    assign speed_right        = speed_right_reg;
    assign signed_total_left  = signed_left_reg;
    assign signed_total_right = signed_right_reg;
    assign travel_total_left  = travel_left_reg;
    assign travel_total_right = travel_right_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> item_valid_reg && result_valid_reg && result_stall)
        else $error("input stalled while the pipeline could move");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("processed beat did not reach the result register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("held beat lost without being processed");

endmodule
